@@ rtl/assert_macros.svh @@
// Assertion macros shared by the line rasterizer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true in a cycle implies consequent true in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Antecedent true in a cycle implies consequent true in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/blpg_pkg.sv @@
// Types and constants for the Bresenham line pixel generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package blpg_pkg;

    localparam int DEF_SCREEN_WIDTH  = 320;
    localparam int DEF_SCREEN_HEIGHT = 240;
    localparam int QUEUE_DEPTH       = 2;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef struct packed {
        op_t                operation;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic [31:0]        draw_color;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic [31:0]        pixel_color;
        logic               visible;
        logic               last;
    } out_item_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        op_t                operation;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic [15:0]        abs_dx;
        logic [15:0]        abs_dy;
        logic               x_neg;
        logic               y_neg;
        logic [31:0]        color;
    } cmd_t;

endpackage

`default_nettype wire

@@ rtl/bresenham_line_pixel_generator_unit.sv @@
// Bresenham line pixel generator: a start item gives the first pixel, each step the next.
// Each item passes the front register, the command queue and the output register in turn.
// Throughput: one item per cycle while m_ready does not hold the output, set by the single
// add-compare error update in the back stage. Reset (aresetn low, synchronous) empties the
// pipeline and queue and leaves the generator idle with no line.
`default_nettype none

module bresenham_line_pixel_generator_unit
    import blpg_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    logic fq_valid;
    logic fq_ready;
    cmd_t fq_data;
    logic qb_valid;
    logic qb_ready;
    cmd_t qb_data;

    blpg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd_data  (fq_data)
    );

    blpg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    blpg_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd_data  (qb_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

@@ rtl/blpg_front.sv @@
// Front stage: accepts input items and precomputes line deltas for start commands.
// Depends on blpg_pkg.
`default_nettype none

module blpg_front
    import blpg_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          cmd_valid,
    input  wire logic     cmd_ready,
    output cmd_t          cmd_data
);

    logic        valid_reg;
    cmd_t        cmd_reg;
    cmd_t        cmd_next;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [16:0] dx_abs;
    logic signed [16:0] dy_abs;

    assign s_ready   = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd_data  = cmd_reg;

    always_comb begin
        dx     = 17'(s_data.end_x) - 17'(s_data.start_x);
        dy     = 17'(s_data.end_y) - 17'(s_data.start_y);
        dx_abs = dx[16] ? -dx : dx;
        dy_abs = dy[16] ? -dy : dy;
        cmd_next.operation = s_data.operation;
        cmd_next.start_x   = s_data.start_x;
        cmd_next.start_y   = s_data.start_y;
        cmd_next.end_x     = s_data.end_x;
        cmd_next.end_y     = s_data.end_y;
        cmd_next.abs_dx    = dx_abs[15:0];
        cmd_next.abs_dy    = dy_abs[15:0];
        cmd_next.x_neg     = dx[16];
        cmd_next.y_neg     = dy[16];
        cmd_next.color     = s_data.draw_color;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/blpg_queue.sv @@
// Short command queue between the front and back stages.
// Depends on blpg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module blpg_queue
    import blpg_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire cmd_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      out_data
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            entry_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            push;
    logic            pop;

    assign in_ready  = count_reg < CntW'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        if (p == PtrW'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

    // The fill count never exceeds the depth, and the pointers are equal when the queue is empty or full.
    `ASSERT_IMPLIES(a_q_count_bound, aclk, aresetn, 1'b1,
        count_reg <= CntW'(QUEUE_DEPTH))
    `ASSERT_IMPLIES(a_q_ptr_match, aclk, aresetn,
        count_reg == '0 || count_reg == CntW'(QUEUE_DEPTH), wr_ptr_reg == rd_ptr_reg)

endmodule

`default_nettype wire

@@ rtl/blpg_back.sv @@
// Back stage: holds the line state, runs the Bresenham update and registers each pixel.
// Depends on blpg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module blpg_back
    import blpg_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_item_t m_data
);

    localparam logic signed [15:0] ScrW = 16'(SCREEN_WIDTH);
    localparam logic signed [15:0] ScrH = 16'(SCREEN_HEIGHT);

    logic               active_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;
    logic signed [15:0] cur_x_reg;
    logic signed [15:0] cur_y_reg;
    logic signed [15:0] target_x_reg;
    logic signed [15:0] target_y_reg;
    logic [15:0]        abs_dx_reg;
    logic [15:0]        abs_dy_reg;
    logic               x_neg_reg;
    logic               y_neg_reg;
    logic signed [17:0] err_reg;
    logic [31:0]        color_reg;

    logic               pop;
    logic               is_start;
    logic               emit;
    logic signed [18:0] e2;
    logic signed [18:0] dx19;
    logic signed [18:0] dy19;
    logic               move_x;
    logic               move_y;
    logic signed [17:0] step_err;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [17:0] err_next;
    logic [31:0]        color_next;
    logic               fin;
    logic               vis;

    assign cmd_ready = !m_valid_reg || m_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign is_start  = cmd_data.operation == OP_START;
    // A step with no line in progress is consumed without a pixel.
    assign emit      = pop && (is_start || active_reg);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        e2       = {err_reg, 1'b0};
        dx19     = $signed({3'b000, abs_dx_reg});
        dy19     = $signed({3'b000, abs_dy_reg});
        move_x   = e2 > -dy19;
        move_y   = e2 < dx19;
        step_err = err_reg - (move_x ? $signed({2'b00, abs_dy_reg}) : 18'sd0)
                           + (move_y ? $signed({2'b00, abs_dx_reg}) : 18'sd0);
        if (is_start) begin
            nx         = cmd_data.start_x;
            ny         = cmd_data.start_y;
            tx         = cmd_data.end_x;
            ty         = cmd_data.end_y;
            err_next   = $signed({2'b00, cmd_data.abs_dx}) - $signed({2'b00, cmd_data.abs_dy});
            color_next = cmd_data.color;
        end else begin
            nx         = move_x ? (x_neg_reg ? cur_x_reg - 16'sd1 : cur_x_reg + 16'sd1)
                                : cur_x_reg;
            ny         = move_y ? (y_neg_reg ? cur_y_reg - 16'sd1 : cur_y_reg + 16'sd1)
                                : cur_y_reg;
            tx         = target_x_reg;
            ty         = target_y_reg;
            err_next   = step_err;
            color_next = color_reg;
        end
        fin = (nx == tx) && (ny == ty);
        vis = !nx[15] && (nx < ScrW) && !ny[15] && (ny < ScrH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                active_reg  <= !fin;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            cur_x_reg   <= nx;
            cur_y_reg   <= ny;
            err_reg     <= err_next;
            color_reg   <= color_next;
            m_data_reg.pixel_x     <= nx;
            m_data_reg.pixel_y     <= ny;
            m_data_reg.pixel_color <= color_next;
            m_data_reg.visible     <= vis;
            m_data_reg.last        <= fin;
        end
        if (pop && is_start) begin
            target_x_reg <= cmd_data.end_x;
            target_y_reg <= cmd_data.end_y;
            abs_dx_reg   <= cmd_data.abs_dx;
            abs_dy_reg   <= cmd_data.abs_dy;
            x_neg_reg    <= cmd_data.x_neg;
            y_neg_reg    <= cmd_data.y_neg;
        end
    end

    `ASSERT_IMPLIES(a_emit_has_room, aclk, aresetn, emit, !m_valid_reg || m_ready)
    `ASSERT_NEXT(a_last_goes_idle, aclk, aresetn, emit && fin, !active_reg)
    `ASSERT_IMPLIES(a_last_at_target, aclk, aresetn, m_valid_reg && m_data_reg.last,
        m_data_reg.pixel_x == target_x_reg && m_data_reg.pixel_y == target_y_reg)

endmodule

`default_nettype wire

@@ bench/blpg_pixel_checker.sv @@
`timescale 1ns / 100ps
// Pixel scoreboard for the Bresenham line pixel generator: predicts each pixel from the
// accepted input transfers and compares it with the result transfers. Depends on blpg_pkg.
module blpg_pixel_checker
    import blpg_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_ready,
    input  wire in_item_t  s_data,
    input  wire logic      m_valid,
    input  wire logic      m_ready,
    input  wire out_item_t m_data,
    output int             fail_count,
    output int             outstanding,
    output int             pixels_seen,
    output int             visible_seen,
    output int             lines_done
);

    // Rasterizer state as the predictor sees it.
    logic signed [15:0] pos_x, pos_y, goal_x, goal_y;
    logic [15:0]        run_x, run_y;
    logic               neg_x, neg_y;
    logic signed [17:0] err;
    logic [31:0]        ink;
    logic               drawing;
    out_item_t          pending_pixels[$];

    function automatic out_item_t pixel_here();
        out_item_t px;
        px.pixel_x     = pos_x;
        px.pixel_y     = pos_y;
        px.pixel_color = ink;
        px.visible     = pos_x >= 0 && pos_x < SCREEN_WIDTH &&
                         pos_y >= 0 && pos_y < SCREEN_HEIGHT;
        px.last        = pos_x == goal_x && pos_y == goal_y;
        drawing        = !px.last;
        return px;
    endfunction

    function automatic bit next_pixel(input in_item_t it, output out_item_t px);
        int span_x, span_y, twice_err, rx, ry;
        if (it.operation == OP_START) begin
            pos_x  = it.start_x;
            pos_y  = it.start_y;
            goal_x = it.end_x;
            goal_y = it.end_y;
            ink    = it.draw_color;
            span_x = int'(goal_x) - int'(pos_x);
            span_y = int'(goal_y) - int'(pos_y);
            neg_x  = span_x < 0;
            neg_y  = span_y < 0;
            rx     = neg_x ? -span_x : span_x;
            ry     = neg_y ? -span_y : span_y;
            run_x  = 16'(rx);
            run_y  = 16'(ry);
            err    = 18'(rx - ry);
            px     = pixel_here();
            return 1'b1;
        end
        if (!drawing) begin
            return 1'b0;
        end
        rx = run_x;
        ry = run_y;
        // Both axis decisions use the doubled error from before this step.
        twice_err = 2 * int'(err);
        if (twice_err > -ry) begin
            err   = 18'(int'(err) - ry);
            pos_x = neg_x ? pos_x - 16'sd1 : pos_x + 16'sd1;
        end
        if (twice_err < rx) begin
            err   = 18'(int'(err) + rx);
            pos_y = neg_y ? pos_y - 16'sd1 : pos_y + 16'sd1;
        end
        px = pixel_here();
        return 1'b1;
    endfunction

    always @(posedge aclk) begin : watch
        out_item_t px, want;
        if (!aresetn) begin
            pos_x   = '0;
            pos_y   = '0;
            goal_x  = '0;
            goal_y  = '0;
            run_x   = '0;
            run_y   = '0;
            neg_x   = 1'b0;
            neg_y   = 1'b0;
            err     = '0;
            ink     = '0;
            drawing = 1'b0;
            pending_pixels.delete();
            fail_count   = 0;
            pixels_seen  = 0;
            visible_seen = 0;
            lines_done   = 0;
        end else begin
            if (s_valid && s_ready) begin
                if (next_pixel(s_data, px)) begin
                    pending_pixels.push_back(px);
                end
            end
            if (m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    $error("pixel transfer with no pixel expected: x %0d y %0d",
                           m_data.pixel_x, m_data.pixel_y);
                    fail_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (m_data.pixel_x !== want.pixel_x) begin
                        $error("pixel_x: expected %0d, got %0d", want.pixel_x, m_data.pixel_x);
                        fail_count++;
                    end
                    if (m_data.pixel_y !== want.pixel_y) begin
                        $error("pixel_y: expected %0d, got %0d", want.pixel_y, m_data.pixel_y);
                        fail_count++;
                    end
                    if (m_data.pixel_color !== want.pixel_color) begin
                        $error("pixel_color: expected %h, got %h",
                               want.pixel_color, m_data.pixel_color);
                        fail_count++;
                    end
                    if (m_data.visible !== want.visible) begin
                        $error("visible: expected %b, got %b", want.visible, m_data.visible);
                        fail_count++;
                    end
                    if (m_data.last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, m_data.last);
                        fail_count++;
                    end
                    pixels_seen++;
                    visible_seen += want.visible;
                    lines_done   += want.last;
                end
            end
        end
        outstanding <= pending_pixels.size();
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the line rasterizer bench: clock, reset, input and output traffic, verdict.
// Depends on blpg_pkg, bresenham_line_pixel_generator_unit and blpg_pixel_checker.
module tb_top;
    import blpg_pkg::*;

    localparam int RANDOM_ITEMS = 1150;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int fail_count, outstanding, pixels_seen, visible_seen, lines_done;
    int burst_left = 0;
    int steps_left = 0;
    int items_sent = 0;
    int rx_mode    = 0;
    int rx_left    = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    bresenham_line_pixel_generator_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    blpg_pixel_checker pixel_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .pixels_seen  (pixels_seen),
        .visible_seen (visible_seen),
        .lines_done   (lines_done)
    );

    // The pixel consumer switches between stretches of free flow, random stalls,
    // heavy back-pressure and a fixed on/off rhythm.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(3);
            rx_left = $urandom_range(4, 40);
        end
        rx_left--;
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(1) == 1;
            2: m_ready <= $urandom_range(3) == 0;
            default: m_ready <= (rx_left % 8) < 5;
        endcase
    end

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int clamp16(int v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    function automatic int line_len(int sx, int sy, int ex, int ey);
        int ax, ay;
        ax = ex > sx ? ex - sx : sx - ex;
        ay = ey > sy ? ey - sy : sy - ey;
        return ax > ay ? ax : ay;
    endfunction

    function automatic in_item_t step_item();
        in_item_t it;
        it.operation  = OP_STEP;
        it.start_x    = 16'($urandom);
        it.start_y    = 16'($urandom);
        it.end_x      = 16'($urandom);
        it.end_y      = 16'($urandom);
        it.draw_color = $urandom;
        return it;
    endfunction

    function automatic in_item_t noise_item();
        in_item_t it;
        it           = step_item();
        it.operation = op_t'($urandom_range(1));
        return it;
    endfunction

    // One input transfer. Steps past the end of a line are ignored by the block and
    // are not counted as work.
    task automatic push_item(input in_item_t it);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (it.operation == OP_START) begin
            items_sent++;
            steps_left = line_len(it.start_x, it.start_y, it.end_x, it.end_y);
        end else if (steps_left > 0) begin
            items_sent++;
            steps_left--;
        end
    endtask

    task automatic start_line(input int sx, input int sy, input int ex, input int ey,
                              input logic [31:0] color, input int n_steps);
        in_item_t it;
        it.operation  = OP_START;
        it.start_x    = 16'(sx);
        it.start_y    = 16'(sy);
        it.end_x      = 16'(ex);
        it.end_y      = 16'(ey);
        it.draw_color = color;
        push_item(it);
        repeat (n_steps) push_item(step_item());
    endtask

    task automatic wait_for_pixels();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int sx, sy, ex, ey, pick, extra, target;
        bit drained;
        drained = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: idle step, single-pixel lines at the coordinate extremes, a step after
        // a finished line, lines crossing every screen edge, and full-span lines that are
        // abandoned by the next start.
        push_item(step_item());
        start_line(-32768, -32768, -32768, -32768, 32'h0000_0000, 0);
        start_line(32767, 32767, 32767, 32767, 32'hFFFF_FFFF, 1);
        start_line(0, 0, 3, 1, $urandom, 4);
        start_line(319, 239, 321, 243, $urandom, 4);
        start_line(1, 0, -1, -3, $urandom, 3);
        start_line(-32768, 32767, 32767, -32768, $urandom, 3);
        start_line(32767, -32768, -32768, 32767, $urandom, 2);

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            if (!drained && items_sent >= target - RANDOM_ITEMS / 2) begin
                wait_for_pixels();
                drained = 1'b1;
            end
            pick  = $urandom_range(99);
            extra = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
            sx    = rand_between(-16, 335);
            sy    = rand_between(-16, 255);
            if (pick < 55) begin
                ex = sx + rand_between(-10, 10);
                ey = sy + rand_between(-10, 10);
                start_line(sx, sy, ex, ey, $urandom, line_len(sx, sy, ex, ey) + extra);
            end else if (pick < 70) begin
                sx = rand_between(-32768, 32767);
                sy = rand_between(-32768, 32767);
                ex = clamp16(sx + rand_between(-12, 12));
                ey = clamp16(sy + rand_between(-12, 12));
                start_line(sx, sy, ex, ey, $urandom, line_len(sx, sy, ex, ey) + extra);
            end else if (pick < 80) begin
                // Long lines are only walked a short way before the next start.
                start_line(rand_between(-32768, 32767), rand_between(-32768, 32767),
                           rand_between(-32768, 32767), rand_between(-32768, 32767),
                           $urandom, $urandom_range(15));
            end else if (pick < 85) begin
                start_line(sx, sy, sx, sy, $urandom, $urandom_range(1));
            end else if (pick < 92) begin
                ex = rand_between(-12, 12);
                case ($urandom_range(2))
                    0: begin
                        ey = sy;
                        ex = sx + ex;
                    end
                    1: begin
                        ey = sy + ex;
                        ex = sx;
                    end
                    default: begin
                        ey = sy - ex;
                        ex = sx + ex;
                    end
                endcase
                start_line(sx, sy, ex, ey, $urandom, line_len(sx, sy, ex, ey) + extra);
            end else begin
                push_item(noise_item());
            end
        end

        wait_for_pixels();
        repeat (10) @(posedge aclk);
        $display("Run covered %0d working input transfers and %0d pixels, %0d of them on screen,",
                 items_sent, pixels_seen, visible_seen);
        $display("with %0d lines walked to their endpoint.", lines_done);
        if (fail_count == 0) begin
            $display("bresenham_line_pixel_generator_unit regression: pass");
        end else begin
            $display("bresenham_line_pixel_generator_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Run stopped on timeout with %0d pixels still expected.", outstanding);
        $display("bresenham_line_pixel_generator_unit regression: fail");
        $finish;
    end

endmodule
